### rtl/secs_pkg.sv
package secs_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned HDR_BYTES       = 10;
	localparam int unsigned PREFIX_BYTES    = 4;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_ITEM   = 3'd1,
		KIND_ELEM   = 3'd2,
		KIND_END    = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	localparam logic [5:0] FMT_LIST = 6'd0;

	// result record, 182 bits: kind travels in tuser, the rest in tdata
	typedef struct packed {
		logic [4:0]  nesting_depth;
		logic [63:0] element_value;
		logic [23:0] item_length;
		logic [5:0]  format_code;
		logic [31:0] system_bytes;
		logic [7:0]  s_type;
		logic [7:0]  p_type;
		logic [7:0]  function_number;
		logic        reply_expected;
		logic [6:0]  stream_number;
		logic [15:0] session_id;
		logic [2:0]  result_kind;
	} result_t;

	// element size in bytes, minus one
	function automatic logic [2:0] elem_size_m1(input logic [5:0] fmt);
		case (fmt)
			6'd18, 6'd26, 6'd42: elem_size_m1 = 3'd1;
			6'd28, 6'd36, 6'd44: elem_size_m1 = 3'd3;
			6'd24, 6'd32, 6'd40: elem_size_m1 = 3'd7;
			default:             elem_size_m1 = 3'd0;
		endcase
	endfunction

endpackage

### rtl/secs_out_fifo.sv
module secs_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  secs_pkg::result_t push_data,
	output logic [1:0]        count,
	input  logic              pop,
	output logic              not_empty,
	output secs_pkg::result_t head
);
	import secs_pkg::*;

	result_t    buf_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	assign count     = cnt_q;
	assign not_empty = cnt_q != 2'd0;
	assign head      = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= push_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && cnt_q == 2'd2 && !pop))
		else $error("result buffer overrun");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && cnt_q == 2'd0))
		else $error("result buffer underrun");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result count out of range");

endmodule

### rtl/secs_ii_message_parser_top.sv
// channel | handshake         | payload
// s_axis  | s_tvalid s_tready | s_tdata: data_byte; s_tlast: last_byte
// m_axis  | m_tvalid m_tready | m_tuser: result_kind; m_tdata: all other result fields
// a taken byte is decoded in the idle state and completed in the finish state; the next byte waits for idle.
// closing lists walks the stack memory: a read state and a pop state (write back) per stack entry touched.
// the next byte waits until the two-entry result buffer is empty and no result is in flight,
// so a low m_tready holds off the input.
// reset clears all control state; header and stack memories are not cleared.
module secs_ii_message_parser_top #(
	parameter int unsigned STACK_DEPTH = secs_pkg::STACK_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [2:0]   m_tuser,   // result_kind
	output logic [183:0] m_tdata    // session_id, stream_number, reply_expected,
	                                // function_number, p_type, s_type, system_bytes,
	                                // format_code, item_length, element_value,
	                                // nesting_depth
);
	import secs_pkg::*;

	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef enum logic [2:0] {PH_PREFIX, PH_HEADER, PH_FORMAT, PH_LENGTH, PH_DATA} phase_t;
	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_POP, ST_FINISH} state_t;

	phase_t      phase_q, phase_d;
	state_t      state_q, state_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [7:0]  hdr_mem [HDR_BYTES];
	logic [5:0]  fmt_q, fmt_d;
	logic [1:0]  lbl_q, lbl_d;
	logic [23:0] lacc_q, lacc_d;
	logic [23:0] ibl_q, ibl_d;
	logic [63:0] shift_q, shift_d;
	logic [SPW-1:0] sp_q, sp_d;
	logic        err_q, err_d;
	logic        last_q, last_d;
	// pending error report: raised by a fault, shown once in the finish cycle
	logic        errp_q, errp_d;
	logic [23:0] stk_mem [STACK_DEPTH];
	logic [23:0] stk_rd_q;

	logic        push_q, push_d;
	result_t     pdata_q, res_d;
	logic [1:0]  fcount;
	logic        fne;
	result_t     fhead;

	secs_out_fifo u_fifo (
		.clk, .arst_n, .push(push_q), .push_data(pdata_q), .count(fcount),
		.pop(m_tvalid && m_tready), .not_empty(fne), .head(fhead)
	);

	assign m_tvalid = fne;
	assign m_tuser  = fhead.result_kind;
	assign m_tdata  = {5'd0, fhead[$bits(result_t)-1:3]};
	// two results may follow one byte, so start only on an empty buffer
	assign s_tready = (state_q == ST_IDLE) && (fcount == 2'd0) && !push_q;
	wire take = s_tvalid && s_tready;

	logic [AW-1:0] top_idx;
	assign top_idx = AW'(sp_q - SPW'(1));
	wire [23:0] dec = stk_rd_q - 24'd1;

	function automatic logic [5:0] cur_fmt();
		cur_fmt = (phase_q == PH_FORMAT) ? s_tdata[7:2] : fmt_q;
	endfunction

	// combinational decode of a taken byte
	logic [23:0] len_c;
	logic        hdr_c, need_close_c, push_list_c, fault_c;
	logic [7:0]  nlacc_lo;
	always_comb begin
		nlacc_lo = s_tdata;
		len_c = 24'd0; hdr_c = 1'b0; need_close_c = 1'b0; push_list_c = 1'b0; fault_c = 1'b0;
		if (phase_q == PH_FORMAT && s_tdata[1:0] == 2'd0) begin
			hdr_c = 1'b1; len_c = 24'd0;
		end else if (phase_q == PH_LENGTH && lbl_q == 2'd1) begin
			hdr_c = 1'b1; len_c = {lacc_q[15:0], nlacc_lo};
		end
		if (hdr_c) begin
			if (cur_fmt() == FMT_LIST) begin
				if (len_c == 24'd0) need_close_c = 1'b1;
				else if (sp_q >= SPW'(STACK_DEPTH)) fault_c = 1'b1;
				else push_list_c = 1'b1;
			end else if ((len_c[2:0] & elem_size_m1(cur_fmt())) != 3'd0) begin
				fault_c = 1'b1;
			end else if (len_c == 24'd0) begin
				need_close_c = 1'b1;
			end
		end
	end

	wire elem_done = (phase_q == PH_DATA) && (cnt_q[2:0] == elem_size_m1(fmt_q));
	wire data_close = elem_done && (ibl_q == 24'd1);

	always_ff @(posedge clk) begin
		if (take && !err_q && phase_q == PH_HEADER) hdr_mem[cnt_q] <= s_tdata;
		if (take && !err_q && push_list_c) stk_mem[AW'(sp_q)] <= len_c;
		if (state_q == ST_POP && dec != 24'd0) stk_mem[top_idx] <= dec;
		stk_rd_q <= stk_mem[top_idx];
	end

	always_comb begin
		phase_d = phase_q; state_d = state_q; cnt_d = cnt_q; fmt_d = fmt_q; lbl_d = lbl_q;
		lacc_d = lacc_q; ibl_d = ibl_q; shift_d = shift_q; sp_d = sp_q; err_d = err_q;
		last_d = last_q; errp_d = errp_q; push_d = 1'b0; res_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					last_d = s_tlast;
					state_d = ST_FINISH;
					if (!err_q) begin
						case (phase_q)
							PH_PREFIX: begin
								if (cnt_q == 4'(PREFIX_BYTES - 1)) begin
									cnt_d = '0; phase_d = PH_HEADER;
								end else cnt_d = cnt_q + 4'd1;
							end
							PH_HEADER: begin
								if (cnt_q == 4'(HDR_BYTES - 1)) begin
									push_d = 1'b1;
									res_d.result_kind     = KIND_HEADER;
									res_d.session_id      = {hdr_mem[0], hdr_mem[1]};
									res_d.stream_number   = hdr_mem[2][6:0];
									res_d.reply_expected  = hdr_mem[2][7];
									res_d.function_number = hdr_mem[3];
									res_d.p_type          = hdr_mem[4];
									res_d.s_type          = hdr_mem[5];
									res_d.system_bytes    = {hdr_mem[6], hdr_mem[7],
										hdr_mem[8], s_tdata};
									cnt_d = '0; phase_d = PH_FORMAT;
								end else cnt_d = cnt_q + 4'd1;
							end
							PH_FORMAT, PH_LENGTH: begin
								if (phase_q == PH_FORMAT) begin
									fmt_d = s_tdata[7:2];
									lbl_d = s_tdata[1:0];
									lacc_d = '0;
									if (s_tdata[1:0] != 2'd0) phase_d = PH_LENGTH;
								end else begin
									lacc_d = {lacc_q[15:0], s_tdata};
									lbl_d = lbl_q - 2'd1;
								end
								if (hdr_c) begin
									push_d = 1'b1;
									res_d.result_kind   = KIND_ITEM;
									res_d.format_code   = cur_fmt();
									res_d.item_length   = len_c;
									res_d.nesting_depth = 5'(sp_q);
									phase_d = PH_FORMAT;
									err_d = fault_c;
									errp_d = fault_c;
									if (push_list_c) sp_d = sp_q + SPW'(1);
									if (cur_fmt() != FMT_LIST && !fault_c && len_c != 24'd0) begin
										ibl_d = len_c; cnt_d = '0; shift_d = '0;
										phase_d = PH_DATA;
									end
									if (need_close_c && sp_q != '0) state_d = ST_READ;
								end
							end
							default: begin
								ibl_d = ibl_q - 24'd1;
								if (elem_done) begin
									push_d = 1'b1;
									res_d.result_kind   = KIND_ELEM;
									res_d.format_code   = fmt_q;
									res_d.element_value = {shift_q[55:0], s_tdata};
									res_d.nesting_depth = 5'(sp_q);
									cnt_d = '0; shift_d = '0;
									if (data_close) begin
										phase_d = PH_FORMAT;
										if (sp_q != '0) state_d = ST_READ;
									end
								end else begin
									cnt_d = cnt_q + 4'd1;
									shift_d = {shift_q[55:0], s_tdata};
								end
							end
						endcase
					end
				end
			end
			ST_READ: state_d = ST_POP;
			ST_POP: begin
				if (dec == 24'd0) begin
					sp_d = sp_q - SPW'(1);
					state_d = (sp_q == SPW'(1)) ? ST_FINISH : ST_READ;
				end else state_d = ST_FINISH;
			end
			default: begin
				state_d = ST_IDLE;
				errp_d = 1'b0;
				if (errp_q) begin
					push_d = 1'b1;
					res_d.result_kind = KIND_ERROR;
				end else if (last_q && !err_q) begin
					push_d = 1'b1;
					res_d.result_kind = (phase_q == PH_FORMAT && sp_q == '0)
						? KIND_END : KIND_ERROR;
				end
				if (last_q) begin
					phase_d = PH_PREFIX; cnt_d = '0; lbl_d = '0; lacc_d = '0;
					ibl_d = '0; shift_d = '0; sp_d = '0; err_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX; state_q <= ST_IDLE; cnt_q <= '0; fmt_q <= '0;
			lbl_q <= '0; lacc_q <= '0; ibl_q <= '0; shift_q <= '0; sp_q <= '0;
			err_q <= 1'b0; last_q <= 1'b0; errp_q <= 1'b0; push_q <= 1'b0; pdata_q <= '0;
		end else begin
			phase_q <= phase_d; state_q <= state_d; cnt_q <= cnt_d; fmt_q <= fmt_d;
			lbl_q <= lbl_d; lacc_q <= lacc_d; ibl_q <= ibl_d; shift_q <= shift_d; sp_q <= sp_d;
			err_q <= err_d; last_q <= last_d; errp_q <= errp_d; push_q <= push_d;
			pdata_q <= res_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer past depth");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_POP |-> sp_q != '0)
		else $error("pop on empty stack");
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> fcount == 2'd0)
		else $error("byte taken without result room");

endmodule
